FILE: hw/rtl/jqss_pkg.sv
// ----------------------------------------------------------------------------
// jqss_pkg
// Shared types, widths and codes for the job queue service station.
// ----------------------------------------------------------------------------
package jqss_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int FUNC_W  = 2;
  localparam int SIZE_W  = 16;
  localparam int NUM_W   = 16;
  localparam int TIME_W  = 32;
  localparam int REM_W   = 17;
  localparam int SUM_W   = 48;
  localparam int DONE_W  = 16;
  localparam int RATE_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ENQUEUE = 2'd0,
    FN_DEQUEUE = 2'd1,
    FN_WORK    = 2'd2,
    FN_TICK    = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_AFTER_WORK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME      = 2'd2;

  // one stored job
  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] entry_time;
  } job_entry_t;

  localparam int ENTRY_W = $bits(job_entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic commit;   // apply the operation and load the result
  } dp_cmd_t;

endpackage

FILE: hw/rtl/jqss_ram.sv
// ----------------------------------------------------------------------------
// jqss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jqss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/jqss_ctrl.sv
// ----------------------------------------------------------------------------
// jqss_ctrl
// Controller: takes one transaction, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
module jqss_ctrl
  import jqss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   commit;

  // handshake decode
  assign take   = (state_r == S_IDLE) && in_valid;
  assign commit = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = take;
  assign cmd.commit  = commit;

endmodule

FILE: hw/rtl/jqss_dp.sv
// ----------------------------------------------------------------------------
// jqss_dp
// Datapath: job FIFO, service station, system clock, totals and result
// registers.
// ----------------------------------------------------------------------------
module jqss_dp
  import jqss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [SIZE_W-1:0]     in_job_size,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_accepted,
  output logic [CNT_W-1:0]      out_queue_length,
  output logic                  out_station_open,
  output logic                  out_job_done,
  output logic [NUM_W-1:0]      out_job_number,
  output logic [TIME_W-1:0]     out_queue_time,
  output logic [TIME_W-1:0]     out_service_time,
  output logic [SUM_W-1:0]      out_total_queue_time,
  output logic [SUM_W-1:0]      out_total_service_time,
  output logic [DONE_W-1:0]     out_completed_count,
  output logic [TIME_W-1:0]     out_system_time
);

  // configuration
  logic [RATE_W-1:0] rate_r;
  logic              tick_r;

  // captured transaction
  func_t             func_r;
  logic [SIZE_W-1:0] size_r;

  // queue and station state
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  logic [NUM_W-1:0]  job_cnt_r, job_cnt_nxt;
  logic [NUM_W-1:0]  held_num_r, held_num_nxt;
  logic [REM_W-1:0]  held_rem_r, held_rem_nxt;
  logic [TIME_W-1:0] held_entry_r, held_entry_nxt;
  logic [TIME_W-1:0] held_start_r, held_start_nxt;
  logic              idle_r, idle_nxt;
  logic [SUM_W-1:0]  sum_q_r, sum_q_nxt;
  logic [SUM_W-1:0]  sum_s_r, sum_s_nxt;
  logic [DONE_W-1:0] done_cnt_r, done_cnt_nxt;

  // result registers
  logic              res_acc_r, res_acc_nxt;
  logic              res_done_r, res_done_nxt;
  logic [NUM_W-1:0]  res_num_r, res_num_nxt;
  logic [TIME_W-1:0] res_qt_r, res_qt_nxt;
  logic [TIME_W-1:0] res_st_r, res_st_nxt;

  // helpers
  job_entry_t        head_entry;
  job_entry_t        wr_entry;
  logic [ENTRY_W-1:0] rd_word;
  logic              ram_we;
  logic [NUM_W-1:0]  job_cnt_inc;
  logic [TIME_W-1:0] clock_work;
  logic [TIME_W-1:0] qtime;
  logic [TIME_W-1:0] stime;
  logic [SUM_W:0]    sum_q_wide;
  logic [SUM_W:0]    sum_s_wide;
  logic              full;
  logic              fin;

  // job store
  jqss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_r),
    .rd_data (rd_word)
  );

  assign head_entry = job_entry_t'(rd_word);

  // common arithmetic
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign job_cnt_inc = job_cnt_r + NUM_W'(1);
  assign clock_work  = clock_r + TIME_W'(tick_r);
  assign fin         = ({1'b0, rate_r} >= held_rem_r);
  assign qtime       = held_start_r - held_entry_r;
  assign stime       = clock_work - held_start_r;
  assign sum_q_wide  = {1'b0, sum_q_r} + {{(SUM_W + 1 - TIME_W){1'b0}}, qtime};
  assign sum_s_wide  = {1'b0, sum_s_r} + {{(SUM_W + 1 - TIME_W){1'b0}}, stime};

  assign wr_entry.number     = job_cnt_inc;
  assign wr_entry.size       = size_r;
  assign wr_entry.entry_time = clock_r;
  assign ram_we = cmd.commit && (func_r == FN_ENQUEUE) && !full;

  // operation decode
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    clock_nxt      = clock_r;
    job_cnt_nxt    = job_cnt_r;
    held_num_nxt   = held_num_r;
    held_rem_nxt   = held_rem_r;
    held_entry_nxt = held_entry_r;
    held_start_nxt = held_start_r;
    idle_nxt       = idle_r;
    sum_q_nxt      = sum_q_r;
    sum_s_nxt      = sum_s_r;
    done_cnt_nxt   = done_cnt_r;
    res_acc_nxt    = 1'b0;
    res_done_nxt   = 1'b0;
    res_num_nxt    = '0;
    res_qt_nxt     = '0;
    res_st_nxt     = '0;
    unique case (func_r)
      FN_ENQUEUE: begin
        if (!full) begin
          job_cnt_nxt = job_cnt_inc;
          tail_nxt    = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
          count_nxt   = count_r + CNT_W'(1);
          res_acc_nxt = 1'b1;
          res_num_nxt = job_cnt_inc;
        end
      end
      FN_DEQUEUE: begin
        if ((count_r != '0) && idle_r) begin
          head_nxt       = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
          count_nxt      = count_r - CNT_W'(1);
          held_num_nxt   = head_entry.number;
          held_rem_nxt   = {1'b0, head_entry.size};
          held_entry_nxt = head_entry.entry_time;
          held_start_nxt = clock_r;
          idle_nxt       = 1'b0;
          res_acc_nxt    = 1'b1;
          res_num_nxt    = head_entry.number;
        end
      end
      FN_WORK: begin
        if (!idle_r) begin
          res_acc_nxt = 1'b1;
          clock_nxt   = clock_work;
          if (fin) begin
            res_done_nxt   = 1'b1;
            res_num_nxt    = held_num_r;
            res_qt_nxt     = qtime;
            res_st_nxt     = stime;
            sum_q_nxt      = sum_q_wide[SUM_W] ? '1 : sum_q_wide[SUM_W-1:0];
            sum_s_nxt      = sum_s_wide[SUM_W] ? '1 : sum_s_wide[SUM_W-1:0];
            done_cnt_nxt   = (done_cnt_r != '1) ? done_cnt_r + DONE_W'(1) : done_cnt_r;
            held_num_nxt   = '0;
            held_rem_nxt   = '0;
            held_entry_nxt = '0;
            held_start_nxt = '0;
            idle_nxt       = 1'b1;
          end else begin
            held_rem_nxt = held_rem_r - {1'b0, rate_r};
          end
        end
      end
      FN_TICK: begin
        clock_nxt = clock_r + TIME_W'(1);
      end
      default: begin
        clock_nxt = clock_r;
      end
    endcase
  end

  // captured transaction, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      size_r <= in_job_size;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_acc_r  <= res_acc_nxt;
      res_done_r <= res_done_nxt;
      res_num_r  <= res_num_nxt;
      res_qt_r   <= res_qt_nxt;
      res_st_r   <= res_st_nxt;
    end
  end

  // configuration registers and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r       <= RATE_W'(1);
      tick_r       <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      clock_r      <= '0;
      job_cnt_r    <= '0;
      held_num_r   <= '0;
      held_rem_r   <= '0;
      held_entry_r <= '0;
      held_start_r <= '0;
      idle_r       <= 1'b1;
      sum_q_r      <= '0;
      sum_s_r      <= '0;
      done_cnt_r   <= '0;
    end else begin
      if (cmd.commit) begin
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        count_r      <= count_nxt;
        clock_r      <= clock_nxt;
        job_cnt_r    <= job_cnt_nxt;
        held_num_r   <= held_num_nxt;
        held_rem_r   <= held_rem_nxt;
        held_entry_r <= held_entry_nxt;
        held_start_r <= held_start_nxt;
        idle_r       <= idle_nxt;
        sum_q_r      <= sum_q_nxt;
        sum_s_r      <= sum_s_nxt;
        done_cnt_r   <= done_cnt_nxt;
      end
      // user writes registers only with no transaction in flight (unchecked)
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SERVICE_RATE:    rate_r  <= cfg_data[RATE_W-1:0];
          CFG_TICK_AFTER_WORK: tick_r  <= cfg_data[0];
          CFG_START_TIME:      clock_r <= cfg_data[TIME_W-1:0];
          default:             rate_r  <= rate_r;
        endcase
      end
    end
  end

  // outputs: per-step fields from result registers, the rest from state
  assign out_accepted           = res_acc_r;
  assign out_job_done           = res_done_r;
  assign out_job_number         = res_num_r;
  assign out_queue_time         = res_qt_r;
  assign out_service_time       = res_st_r;
  assign out_queue_length       = count_r;
  assign out_station_open       = idle_r;
  assign out_total_queue_time   = sum_q_r;
  assign out_total_service_time = sum_s_r;
  assign out_completed_count    = done_cnt_r;
  assign out_system_time        = clock_r;

endmodule

FILE: hw/rtl/job_queue_service_station_core.sv
// ----------------------------------------------------------------------------
// job_queue_service_station_core
// Single-server FIFO job queue with a service station and system clock.
//
// Input channel (in_valid/in_stall) carries one operation per transaction:
// enqueue, dequeue into the station, work step or time tick. Every input
// transaction produces exactly one result transaction on out_valid/out_stall.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// service rate, the tick-on-work flag and the start time, which also loads
// the system clock. cfg_ready is always high; write only while idle.
// The input is captured into the transaction registers when accepted;
// the result registers and out_valid load at the commit, which waits until
// the result register is free. A new input is not taken before the last one
// commits; the job store is a RAM with a registered read port, so the head
// entry is read in the accept cycle and used in the commit cycle.
// Reset clears the queue, empties the station, zeroes the totals and loads
// the clock with zero. A stalled result holds; one further input transaction
// may be taken meanwhile and waits, stalling the input, until the result
// register is free.
// ----------------------------------------------------------------------------
module job_queue_service_station_core
  import jqss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [SIZE_W-1:0]     in_job_size,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [CNT_W-1:0]      out_queue_length,
  output logic                  out_station_open,
  output logic                  out_job_done,
  output logic [NUM_W-1:0]      out_job_number,
  output logic [TIME_W-1:0]     out_queue_time,
  output logic [TIME_W-1:0]     out_service_time,
  output logic [SUM_W-1:0]      out_total_queue_time,
  output logic [SUM_W-1:0]      out_total_service_time,
  output logic [DONE_W-1:0]     out_completed_count,
  output logic [TIME_W-1:0]     out_system_time,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  jqss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  jqss_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .in_func                (in_func),
    .in_job_size            (in_job_size),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_accepted           (out_accepted),
    .out_queue_length       (out_queue_length),
    .out_station_open       (out_station_open),
    .out_job_done           (out_job_done),
    .out_job_number         (out_job_number),
    .out_queue_time         (out_queue_time),
    .out_service_time       (out_service_time),
    .out_total_queue_time   (out_total_queue_time),
    .out_total_service_time (out_total_service_time),
    .out_completed_count    (out_completed_count),
    .out_system_time        (out_system_time)
  );

endmodule
